[rtl/rlq_pkg.sv]
`timescale 1ns / 1ps
package rlq_pkg;

  localparam int TID_W = 7;

  typedef logic [1:0]       cmd_t;
  typedef logic [1:0]       status_t;
  typedef logic [TID_W-1:0] tid_t;

  localparam cmd_t CMD_ENQUEUE = 2'd0;
  localparam cmd_t CMD_DEQUEUE = 2'd1;
  localparam cmd_t CMD_REMOVE  = 2'd2;
  localparam cmd_t CMD_QUERY   = 2'd3;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_EMPTY  = 2'd1;
  localparam status_t ST_ABSENT = 2'd2;
  localparam status_t ST_DUP    = 2'd3;

endpackage

[rtl/rlq_link_ram.sv]
`timescale 1ns / 1ps
module rlq_link_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/linked_ready_queue.sv]
`timescale 1ns / 1ps
// Query, rejects, empty dequeue and enqueue onto an empty queue finish in the execute state;
// dequeue, remove of the head and enqueue onto a non-empty queue pass through a further state
// (dequeue, head fix or tail link). Remove of any other id walks the list from the head with
// one link-table read per hop, then rewrites its predecessor's link. Busy drops in the strobe
// cycle, so a new request can be accepted while done is high; no request is taken before the
// last one is done. Results cannot be stalled. Synchronous reset empties the queue.
module linked_ready_queue #(
  parameter int MAX_THREADS = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  rlq_pkg::cmd_t    cmd,
  input  rlq_pkg::tid_t    tid,
  output logic             done,
  output rlq_pkg::tid_t    result_tid,
  output rlq_pkg::status_t status
);
  import rlq_pkg::*;

  localparam int DEPTH = (MAX_THREADS < (1 << TID_W)) ? MAX_THREADS : (1 << TID_W);
  localparam int IW    = $clog2(DEPTH);
  localparam int LW    = IW + 1;
  localparam logic [LW-1:0] NULL_LINK = '1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_ENQ_LINK = 3'd2;
  localparam logic [2:0] S_DEQ      = 3'd3;
  localparam logic [2:0] S_RM_HEAD  = 3'd4;
  localparam logic [2:0] S_WALK     = 3'd5;
  localparam logic [2:0] S_RM_FIX   = 3'd6;

  logic [2:0]       state, state_next;
  cmd_t             cmd_q;
  tid_t             tid_q;
  logic [LW-1:0]    head, head_next;
  logic [LW-1:0]    tail, tail_next;
  logic [LW-1:0]    prev, prev_next;
  logic [DEPTH-1:0] flags, flags_next;
  logic             done_next;
  tid_t             result_tid_next;
  status_t          status_next;

  logic             id_ok;
  logic [IW-1:0]    id_idx;
  logic [LW-1:0]    id_link;
  logic             flag_hit;

  logic             we;
  logic [IW-1:0]    wr_addr;
  logic [LW-1:0]    wr_data;
  logic [IW-1:0]    rd_addr;
  logic [LW-1:0]    rd_data;

  rlq_link_ram #(
    .DEPTH(DEPTH),
    .AW   (IW),
    .DW   (LW)
  ) u_link_ram (
    .clk    (clk),
    .we     (we),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign busy     = (state != S_IDLE);
  assign id_ok    = (int'(tid_q) < MAX_THREADS);
  assign id_idx   = tid_q[IW-1:0];
  assign id_link  = {1'b0, id_idx};
  assign flag_hit = id_ok && flags[id_idx];

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    prev_next       = prev;
    flags_next      = flags;
    done_next       = 1'b0;
    result_tid_next = result_tid;
    status_next     = status;
    we              = 1'b0;
    wr_addr         = id_idx;
    wr_data         = NULL_LINK;
    rd_addr         = head[IW-1:0];

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (cmd_q == CMD_DEQUEUE) begin
          if (head == NULL_LINK) begin
            state_next      = S_IDLE;
            done_next       = 1'b1;
            result_tid_next = '0;
            status_next     = ST_EMPTY;
          end else begin
            rd_addr    = head[IW-1:0];
            state_next = S_DEQ;
          end
        end else if (!id_ok) begin
          state_next      = S_IDLE;
          done_next       = 1'b1;
          result_tid_next = '0;
          status_next     = ST_ABSENT;
        end else begin
          case (cmd_q)
            CMD_ENQUEUE: begin
              if (flag_hit) begin
                state_next      = S_IDLE;
                done_next       = 1'b1;
                result_tid_next = '0;
                status_next     = ST_DUP;
              end else begin
                we                 = 1'b1;
                wr_addr            = id_idx;
                wr_data            = NULL_LINK;
                flags_next[id_idx] = 1'b1;
                if (head == NULL_LINK) begin
                  head_next       = id_link;
                  tail_next       = id_link;
                  state_next      = S_IDLE;
                  done_next       = 1'b1;
                  result_tid_next = '0;
                  status_next     = ST_OK;
                end else begin
                  state_next = S_ENQ_LINK;
                end
              end
            end
            CMD_REMOVE: begin
              if (!flag_hit) begin
                state_next      = S_IDLE;
                done_next       = 1'b1;
                result_tid_next = '0;
                status_next     = ST_ABSENT;
              end else begin
                flags_next[id_idx] = 1'b0;
                if (head == id_link) begin
                  rd_addr    = id_idx;
                  state_next = S_RM_HEAD;
                end else begin
                  rd_addr    = head[IW-1:0];
                  prev_next  = head;
                  state_next = S_WALK;
                end
              end
            end
            default: begin
              state_next      = S_IDLE;
              done_next       = 1'b1;
              result_tid_next = '0;
              status_next     = flag_hit ? ST_OK : ST_ABSENT;
            end
          endcase
        end
      end

      S_ENQ_LINK: begin
        we              = 1'b1;
        wr_addr         = tail[IW-1:0];
        wr_data         = id_link;
        tail_next       = id_link;
        state_next      = S_IDLE;
        done_next       = 1'b1;
        result_tid_next = '0;
        status_next     = ST_OK;
      end

      S_DEQ: begin
        head_next = rd_data;
        if (rd_data == NULL_LINK) begin
          tail_next = NULL_LINK;
        end
        flags_next[head[IW-1:0]] = 1'b0;
        state_next      = S_IDLE;
        done_next       = 1'b1;
        result_tid_next = tid_t'(head[IW-1:0]);
        status_next     = ST_OK;
      end

      S_RM_HEAD: begin
        head_next = rd_data;
        if (rd_data == NULL_LINK) begin
          tail_next = NULL_LINK;
        end
        state_next      = S_IDLE;
        done_next       = 1'b1;
        result_tid_next = '0;
        status_next     = ST_OK;
      end

      S_WALK: begin
        if (rd_data == id_link) begin
          rd_addr    = id_idx;
          state_next = S_RM_FIX;
        end else begin
          prev_next = rd_data;
          rd_addr   = rd_data[IW-1:0];
        end
      end

      S_RM_FIX: begin
        we      = 1'b1;
        wr_addr = prev[IW-1:0];
        wr_data = rd_data;
        if (rd_data == NULL_LINK) begin
          tail_next = prev;
        end
        state_next      = S_IDLE;
        done_next       = 1'b1;
        result_tid_next = '0;
        status_next     = ST_OK;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= NULL_LINK;
      tail  <= NULL_LINK;
      flags <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      flags <= flags_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd_q <= cmd;
      tid_q <= tid;
    end
    prev       <= prev_next;
    result_tid <= result_tid_next;
    status     <= status_next;
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a request is still in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    (head == NULL_LINK) == (tail == NULL_LINK))
    else $error("head and tail disagree on an empty queue");

  a_walk_prev: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> prev != NULL_LINK)
    else $error("list walk ran off the end");

  a_empty_tid: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_EMPTY |-> result_tid == '0)
    else $error("empty dequeue returned a nonzero id");

endmodule
